// ===== sv/assert_macros.svh =====
// Assertion macros shared by the brake level apogee search RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/blas_pkg.sv =====
// Package for the brake level apogee search: constants, control word types
// and the microcode program. No dependencies.
package blas_pkg;

    localparam int DEF_SCENARIOS   = 16;
    localparam int DEF_CHECKPOINTS = 32;
    localparam int DEF_LEVELS      = 8;

    // Weights are Q2.14; sums of products are kept exactly in Q.14 units.
    localparam int Q_FRAC = 14;
    localparam int PW     = 33;
    localparam int DW     = 36;

    localparam logic [15:0] TARGET_RESET = 16'd3000;

    // Checkpoint is ceil(altitude / 1000), done as (alt + 999) * recip >> shift.
    // The reciprocal error stays below one part in a thousand over 18 bits.
    localparam int CP_DIVISOR = 1000;
    localparam int CP_ROUND   = CP_DIVISOR - 1;
    localparam int CP_SHIFT   = 28;
    localparam int CP_RECIP   = ((1 << CP_SHIFT) + CP_DIVISOR - 1) / CP_DIVISOR;
    localparam int ALTC_W     = 18;
    localparam int CP_RECIP_W = 19;
    localparam int CPP_W      = ALTC_W + CP_RECIP_W;
    localparam int CP_Q_W     = 8;

    localparam logic [1:0] KIND_COMPUTE = 2'd0;
    localparam logic [1:0] KIND_APOGEE  = 2'd1;
    localparam logic [1:0] KIND_PRED    = 2'd2;

    localparam int PC_W     = 4;
    localparam int PROG_LEN = 13;

    localparam logic [PC_W-1:0] PC_START  = 4'd0;
    localparam logic [PC_W-1:0] PC_LOOP   = 4'd6;
    localparam logic [PC_W-1:0] PC_PICK   = 4'd10;
    localparam logic [PC_W-1:0] PC_FINISH = 4'd12;

    // Memory port and multiplier operand selection.
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_A1,
        SRC_A2,
        SRC_P1,
        SRC_P2
    } t_src;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_CUR
    } t_acc;

    typedef enum logic [3:0] {
        MISC_NONE,
        MISC_WRITE_LOAD,
        MISC_CP_DIV,
        MISC_CP_CLAMP,
        MISC_BASE1,
        MISC_BASE2,
        MISC_SEARCH_INIT,
        MISC_LVL_INC,
        MISC_DIFF,
        MISC_CHOOSE,
        MISC_FINISH
    } t_misc;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_COMPUTE,
        COND_PROJ_LE,
        COND_LOOP_DONE,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_src             rd;
        t_src             mul;
        t_acc             acc;
        t_misc            misc;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } t_ctrl;

    typedef struct packed {
        logic not_compute;
        logic proj_le;
        logic loop_done;
        logic out_full;
    } t_status;

    localparam t_ctrl CTRL_NOP = '{rd: SRC_NONE, mul: SRC_NONE, acc: ACC_NONE,
                                   misc: MISC_NONE, cond: COND_NEVER,
                                   target: PC_START, last: 1'b0};

    function automatic t_ctrl uop(input t_src rd, input t_src mul, input t_acc acc,
                                  input t_misc misc, input t_cond cond,
                                  input logic [PC_W-1:0] target, input logic last);
        return '{rd: rd, mul: mul, acc: acc, misc: misc, cond: cond,
                 target: target, last: last};
    endfunction

    // Program: a read issued in one step is multiplied in the next and
    // accumulated in the one after.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            4'd0: w = uop(SRC_NONE, SRC_NONE, ACC_NONE, MISC_WRITE_LOAD,
                          COND_NOT_COMPUTE, PC_FINISH, 1'b0);
            4'd1: w = uop(SRC_A1, SRC_NONE, ACC_NONE, MISC_CP_DIV,
                          COND_NEVER, PC_START, 1'b0);
            4'd2: w = uop(SRC_A2, SRC_A1, ACC_NONE, MISC_CP_CLAMP,
                          COND_NEVER, PC_START, 1'b0);
            4'd3: w = uop(SRC_NONE, SRC_A2, ACC_LOAD, MISC_BASE1,
                          COND_NEVER, PC_START, 1'b0);
            4'd4: w = uop(SRC_NONE, SRC_NONE, ACC_ADD, MISC_BASE2,
                          COND_NEVER, PC_START, 1'b0);
            4'd5: w = uop(SRC_NONE, SRC_NONE, ACC_NONE, MISC_SEARCH_INIT,
                          COND_PROJ_LE, PC_FINISH, 1'b0);
            4'd6: w = uop(SRC_P1, SRC_NONE, ACC_NONE, MISC_NONE,
                          COND_LOOP_DONE, PC_PICK, 1'b0);
            4'd7: w = uop(SRC_P2, SRC_P1, ACC_NONE, MISC_NONE,
                          COND_NEVER, PC_START, 1'b0);
            4'd8: w = uop(SRC_NONE, SRC_P2, ACC_LOAD, MISC_NONE,
                          COND_NEVER, PC_START, 1'b0);
            4'd9: w = uop(SRC_NONE, SRC_NONE, ACC_CUR, MISC_LVL_INC,
                          COND_ALWAYS, PC_LOOP, 1'b0);
            4'd10: w = uop(SRC_NONE, SRC_NONE, ACC_NONE, MISC_DIFF,
                           COND_NEVER, PC_START, 1'b0);
            4'd11: w = uop(SRC_NONE, SRC_NONE, ACC_NONE, MISC_CHOOSE,
                           COND_NEVER, PC_START, 1'b0);
            4'd12: w = uop(SRC_NONE, SRC_NONE, ACC_NONE, MISC_FINISH,
                           COND_OUT_FULL, PC_FINISH, 1'b1);
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/blas_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module blas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/blas_seq.sv =====
// Microcode sequencer: step counter, program fetch and conditional jumps.
// Depends on blas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blas_seq import blas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_busy
);

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    t_ctrl           word;
    logic            taken;

    assign word = ucode(r_pc);

    always_comb begin
        case (word.cond)
            COND_ALWAYS:      taken = 1'b1;
            COND_NOT_COMPUTE: taken = i_status.not_compute;
            COND_PROJ_LE:     taken = i_status.proj_le;
            COND_LOOP_DONE:   taken = i_status.loop_done;
            COND_OUT_FULL:    taken = i_status.out_full;
            default:          taken = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_START;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= PC_START;
            end
        end else if (taken) begin
            r_pc <= word.target;
        end else if (word.last) begin
            r_busy <= 1'b0;
            r_pc   <= PC_START;
        end else begin
            r_pc <= PC_W'(r_pc + 1'b1);
        end
    end

    assign o_ctrl = r_busy ? word : CTRL_NOP;
    assign o_busy = r_busy;

    `ASSERT_NEVER(a_pc_range, i_clk, i_rst_n, r_busy && (r_pc >= PC_W'(PROG_LEN)), "step counter left the program")
    `ASSERT_RST(a_idle_pc, i_clk, i_rst_n, !r_busy |-> (r_pc == PC_START), "idle sequencer not parked at the first step")

endmodule

// ===== sv/blas_dp.sv =====
// Datapath: item and config registers, the two table memories, shared
// multiplier, accumulator, search registers and output register.
// Depends on blas_pkg, blas_ram and assert_macros.svh.
`include "assert_macros.svh"

module blas_dp import blas_pkg::*; #(
    parameter int SCENARIOS   = DEF_SCENARIOS,
    parameter int CHECKPOINTS = DEF_CHECKPOINTS,
    parameter int LEVELS      = DEF_LEVELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_weight_one,
    input  logic signed [15:0] i_weight_two,
    input  logic [7:0]         i_scenario_one,
    input  logic [7:0]         i_scenario_two,
    input  logic [16:0]        i_current_altitude,
    input  logic [11:0]        i_load_index,
    input  logic [15:0]        i_load_value,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  t_ctrl              i_ctrl,
    output t_status            o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_brake_level,
    output logic               o_level_changed
);

    localparam int TABLE_SIZE = SCENARIOS * CHECKPOINTS * LEVELS;
    localparam int AW_A = (SCENARIOS > 1) ? $clog2(SCENARIOS) : 1;
    localparam int TW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW   = $clog2(SCENARIOS + 1);
    localparam int CPW  = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;
    localparam int LW   = $clog2(LEVELS + 1);

    // Item registers.
    logic [1:0]         r_kind;
    logic signed [15:0] r_w1, r_w2;
    logic [7:0]         r_s1, r_s2;
    logic [ALTC_W-1:0]  r_altc;
    logic [11:0]        r_lidx;
    logic [15:0]        r_lval;
    logic               r_v1a, r_v2a, r_v1p, r_v2p;

    // Architectural state.
    logic [15:0]        r_target;
    logic [CW-1:0]      r_count;
    logic [2:0]         r_held;
    logic               r_changed;

    // Work registers.
    logic [CP_Q_W-1:0]  r_q;
    logic [CPW-1:0]     r_cp;
    logic [TW-1:0]      r_base1, r_base2;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_acc, r_cur, r_prev;
    logic [DW-1:0]      r_dp, r_dc;
    logic [LW-1:0]      r_lvl;

    logic               r_out_valid;
    logic [2:0]         r_out_level;
    logic               r_out_changed;

    logic [AW_A-1:0]    apo_raddr;
    logic [15:0]        apo_rdata;
    logic               apo_we;
    logic [TW-1:0]      pred_raddr;
    logic [15:0]        pred_rdata;
    logic               pred_we;

    logic [15:0]          op_d;
    logic signed [15:0]   op_w;
    logic signed [PW-1:0] n_prod;
    logic signed [DW-1:0] prod_ext;
    logic signed [DW-1:0] tgt;
    logic signed [DW-1:0] tgt_plus_one;
    logic signed [DW-1:0] d_prev, d_cur;
    logic [CPP_W-1:0]     cp_prod;
    logic [CPW-1:0]       n_cp;
    logic [LW-1:0]        cand;
    logic [2:0]           n_level;
    logic                 out_full;
    logic                 fin_fire;

    assign tgt = signed'({{(DW - 16 - Q_FRAC){1'b0}}, r_target, {Q_FRAC{1'b0}}});
    assign tgt_plus_one = tgt + (DW'(1) <<< Q_FRAC);

    // Memories.
    assign apo_we  = (i_ctrl.misc == MISC_WRITE_LOAD) && (r_kind == KIND_APOGEE)
                     && (32'(r_lidx) < SCENARIOS);
    assign pred_we = (i_ctrl.misc == MISC_WRITE_LOAD) && (r_kind == KIND_PRED)
                     && (32'(r_lidx) < TABLE_SIZE);
    assign apo_raddr  = (i_ctrl.rd == SRC_A2) ? AW_A'(r_s2) : AW_A'(r_s1);
    assign pred_raddr = TW'(((i_ctrl.rd == SRC_P2) ? r_base2 : r_base1) + TW'(r_lvl));

    blas_ram #(.WIDTH(16), .DEPTH(SCENARIOS)) u_apo_ram (
        .i_clk   (i_clk),
        .i_we    (apo_we),
        .i_waddr (AW_A'(r_lidx)),
        .i_wdata (r_lval),
        .i_raddr (apo_raddr),
        .o_rdata (apo_rdata)
    );

    blas_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (pred_we),
        .i_waddr (TW'(r_lidx)),
        .i_wdata (r_lval),
        .i_raddr (pred_raddr),
        .o_rdata (pred_rdata)
    );

    // Multiplier operands; an unused scenario contributes zero.
    always_comb begin
        case (i_ctrl.mul)
            SRC_A1: begin
                op_d = r_v1a ? apo_rdata : '0;
                op_w = r_w1;
            end
            SRC_A2: begin
                op_d = r_v2a ? apo_rdata : '0;
                op_w = r_w2;
            end
            SRC_P1: begin
                op_d = r_v1p ? pred_rdata : '0;
                op_w = r_w1;
            end
            SRC_P2: begin
                op_d = r_v2p ? pred_rdata : '0;
                op_w = r_w2;
            end
            default: begin
                op_d = '0;
                op_w = '0;
            end
        endcase
    end

    assign n_prod   = $signed({1'b0, op_d}) * op_w;
    assign prod_ext = DW'(r_prod);

    assign cp_prod = CPP_W'(r_altc) * CPP_W'(CP_RECIP);

    always_comb begin
        if (r_q == '0) begin
            n_cp = '0;
        end else if (32'(r_q) > CHECKPOINTS) begin
            n_cp = CPW'(CHECKPOINTS - 1);
        end else begin
            n_cp = CPW'(r_q - 1'b1);
        end
    end

    assign d_prev = r_prev - tgt;
    assign d_cur  = tgt - r_cur;

    // A tie keeps the later level.
    always_comb begin
        cand = LW'(r_lvl - 1'b1);
        if ((r_dp < r_dc) && (cand != '0)) begin
            cand = LW'(cand - 1'b1);
        end
        n_level = 3'(cand);
    end

    assign out_full = r_out_valid && i_out_stall;
    assign fin_fire = (i_ctrl.misc == MISC_FINISH) && !out_full;

    assign o_status.not_compute = (r_kind != KIND_COMPUTE) || (r_count == '0);
    assign o_status.proj_le     = (r_acc <= tgt);
    assign o_status.loop_done   = (r_cur <= tgt) || (r_lvl == LW'(LEVELS));
    assign o_status.out_full    = out_full;

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RESET;
            r_count     <= '0;
            r_held      <= '0;
            r_changed   <= 1'b0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_changed <= 1'b0;
            end
            if (apo_we && (32'(r_lidx) + 1 > 32'(r_count))) begin
                r_count <= CW'(32'(r_lidx) + 1);
            end
            if (i_ctrl.misc == MISC_SEARCH_INIT) begin
                r_lvl <= '0;
            end else if (i_ctrl.misc == MISC_LVL_INC) begin
                r_lvl <= LW'(r_lvl + 1'b1);
            end
            if (i_ctrl.misc == MISC_CHOOSE) begin
                r_held    <= n_level;
                r_changed <= (n_level != r_held);
            end
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and work registers.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind <= i_kind;
            r_w1   <= i_weight_one;
            r_w2   <= i_weight_two;
            r_s1   <= i_scenario_one;
            r_s2   <= i_scenario_two;
            r_altc <= ALTC_W'(i_current_altitude) + ALTC_W'(CP_ROUND);
            r_lidx <= i_load_index;
            r_lval <= i_load_value;
            r_v1a  <= 32'(i_scenario_one) < 32'(r_count);
            r_v2a  <= 32'(i_scenario_two) < 32'(r_count);
            r_v1p  <= 32'(i_scenario_one) < SCENARIOS;
            r_v2p  <= 32'(i_scenario_two) < SCENARIOS;
        end

        r_prod <= n_prod;

        case (i_ctrl.acc)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_ADD:  r_acc <= r_acc + prod_ext;
            ACC_CUR: begin
                r_cur  <= r_acc + prod_ext;
                r_prev <= r_cur;
            end
            default: ;
        endcase

        case (i_ctrl.misc)
            MISC_CP_DIV:   r_q  <= cp_prod[CP_SHIFT +: CP_Q_W];
            MISC_CP_CLAMP: r_cp <= n_cp;
            MISC_BASE1: begin
                r_base1 <= TW'((32'(r_s1) * CHECKPOINTS + 32'(r_cp)) * LEVELS);
            end
            MISC_BASE2: begin
                r_base2 <= TW'((32'(r_s2) * CHECKPOINTS + 32'(r_cp)) * LEVELS);
            end
            MISC_SEARCH_INIT: begin
                r_cur  <= tgt_plus_one;
                r_prev <= tgt_plus_one;
            end
            MISC_DIFF: begin
                r_dp <= d_prev[DW-1] ? DW'(-d_prev) : DW'(d_prev);
                r_dc <= d_cur[DW-1] ? DW'(-d_cur) : DW'(d_cur);
            end
            default: ;
        endcase

        if (fin_fire) begin
            r_out_level   <= r_held;
            r_out_changed <= r_changed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_brake_level   = r_out_level;
    assign o_level_changed = r_out_changed;

    `ASSERT_RST(a_out_rise, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(fin_fire), "result appeared without a finish step")
    `ASSERT_NEVER(a_lvl_range, i_clk, i_rst_n, 32'(r_lvl) > LEVELS, "search level ran past the last level")
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, 32'(r_count) > SCENARIOS, "apogee count exceeds the scenario table")
    `ASSERT_RST(a_changed_flag, i_clk, i_rst_n, (i_ctrl.misc == MISC_CHOOSE) |=> (r_changed == (r_held != $past(r_held))), "change flag disagrees with the stored level")

endmodule

// ===== sv/brake_level_apogee_search.sv =====
// Loads, ignored items and computes before any apogee is loaded go from the write step straight
// to finish; other computes run the checkpoint and base steps, then search unless projected <= target.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Each search level takes two reads of the single table port and two products.
// Synchronous active-low reset clears control, sets the target to 3000 and clears the apogee
// count and stored level; the table memories are not cleared and need no clearing pass.
module brake_level_apogee_search import blas_pkg::*; #(
    parameter int SCENARIOS   = DEF_SCENARIOS,
    parameter int CHECKPOINTS = DEF_CHECKPOINTS,
    parameter int LEVELS      = DEF_LEVELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_weight_one,
    input  logic signed [15:0] i_weight_two,
    input  logic [7:0]         i_scenario_one,
    input  logic [7:0]         i_scenario_two,
    input  logic [16:0]        i_current_altitude,
    input  logic [11:0]        i_load_index,
    input  logic [15:0]        i_load_value,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_brake_level,
    output logic               o_level_changed
);

    logic    busy;
    logic    accept;
    t_ctrl   ctrl;
    t_status status;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    blas_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    blas_dp #(
        .SCENARIOS   (SCENARIOS),
        .CHECKPOINTS (CHECKPOINTS),
        .LEVELS      (LEVELS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_kind             (i_kind),
        .i_weight_one       (i_weight_one),
        .i_weight_two       (i_weight_two),
        .i_scenario_one     (i_scenario_one),
        .i_scenario_two     (i_scenario_two),
        .i_current_altitude (i_current_altitude),
        .i_load_index       (i_load_index),
        .i_load_value       (i_load_value),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_ctrl             (ctrl),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_brake_level      (o_brake_level),
        .o_level_changed    (o_level_changed)
    );

endmodule
